// ===== rtl/core/gdnd_pkg.sv =====
`default_nettype none

package gdnd_pkg;

    // Fixed field widths of the day, month and day-difference fields
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int DDAY_W  = 6;

    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DDAY_W-1:0]  dday_t;

    localparam month_t MON_JAN = 4'd1;
    localparam month_t MON_FEB = 4'd2;
    localparam month_t MON_MAR = 4'd3;
    localparam month_t MON_APR = 4'd4;
    localparam month_t MON_MAY = 4'd5;
    localparam month_t MON_JUN = 4'd6;
    localparam month_t MON_JUL = 4'd7;
    localparam month_t MON_SEP = 4'd9;
    localparam month_t MON_OCT = 4'd10;
    localparam month_t MON_NOV = 4'd11;
    localparam month_t MON_DEC = 4'd12;
    localparam month_t MONTHS_PER_YEAR = 4'd12;

    localparam day_t LEN_28 = 5'd28;
    localparam day_t LEN_29 = 5'd29;
    localparam day_t LEN_30 = 5'd30;
    localparam day_t LEN_31 = 5'd31;

    // Length of month m; codes outside 1..12 fall to 31 and are gated by the valid check
    function automatic day_t month_len(input month_t m, input logic leap);
        day_t len;
        begin
            unique case (m)
                MON_FEB:                            len = leap ? LEN_29 : LEN_28;
                MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
                default:                            len = LEN_31;
            endcase
            return len;
        end
    endfunction

    // Length of the month before m, used when the day borrows
    function automatic day_t prev_month_len(input month_t m, input logic leap);
        day_t len;
        begin
            unique case (m)
                MON_MAR:                            len = leap ? LEN_29 : LEN_28;
                MON_MAY, MON_JUL, MON_OCT, MON_DEC: len = LEN_30;
                default:                            len = LEN_31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gdnd_if.sv =====
`default_nettype none

// Request channel: two dates
interface gdnd_req_if
    import gdnd_pkg::*;
#(
    parameter int YEAR_BITS = 14
) ();
    logic                 valid;
    logic                 ready;
    day_t                 first_day;
    month_t               first_month;
    logic [YEAR_BITS-1:0] first_year;
    day_t                 second_day;
    month_t               second_month;
    logic [YEAR_BITS-1:0] second_year;

    modport source (
        output valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        input  ready
    );
    modport sink (
        input  valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        output ready
    );
endinterface

// Response channel: validity, next date and difference
interface gdnd_rsp_if
    import gdnd_pkg::*;
#(
    parameter int YEAR_BITS = 14
) ();
    logic                        valid;
    logic                        ready;
    logic                        first_valid;
    logic                        second_valid;
    day_t                        next_day;
    month_t                      next_month;
    logic [YEAR_BITS-1:0]        next_year;
    logic                        next_overflow;
    logic signed [YEAR_BITS:0]   diff_years;
    month_t                      diff_months;
    logic signed [DDAY_W-1:0]    diff_days;

    modport source (
        output valid, first_valid, second_valid, next_day, next_month, next_year,
               next_overflow, diff_years, diff_months, diff_days,
        input  ready
    );
    modport sink (
        input  valid, first_valid, second_valid, next_day, next_month, next_year,
               next_overflow, diff_years, diff_months, diff_days,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/gdnd_div25.sv =====
`default_nettype none

// Registered quotient y / 25 by reciprocal multiply; exact over the whole year range
module gdnd_div25
    import gdnd_pkg::*;
#(
    parameter int YEAR_BITS = 14
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [YEAR_BITS-1:0]   y,
    output logic      [YEAR_BITS-5:0]   q_reg
);
    localparam int SHIFT  = YEAR_BITS + 5;
    localparam int MUL    = ((1 << SHIFT) + 24) / 25;
    localparam int PROD_W = 2 * YEAR_BITS + 1;
    localparam int Q_W    = YEAR_BITS - 4;
    localparam logic [YEAR_BITS:0] MUL_V = MUL[YEAR_BITS:0];

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q_next;

    assign prod   = PROD_W'(y) * PROD_W'(MUL_V);
    assign q_next = prod[SHIFT +: Q_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/core/gregorian_date_next_and_difference_unit.sv =====
`default_nettype none

// Gregorian date checker, next-date stepper and date difference. Takes one item
// per clock cycle unless the output stalls. Each item passes through one stage
// for the divide-by-25 reciprocal multiply used by the century leap rule, one
// for the leap flags, month lengths and validity, and the output register
// holding the next date and the borrow-style difference. Valid bits travel with
// each stage, and a stage advances whenever it is empty or the stage after it
// advances, so bubbles close up while the output waits to be taken.
module gregorian_date_next_and_difference_unit
    import gdnd_pkg::*;
#(
    parameter int YEAR_BITS = 14
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gdnd_req_if.sink    req,
    gdnd_rsp_if.source  rsp
);
    localparam int Q_W = YEAR_BITS - 4;
    typedef logic [YEAR_BITS-1:0] year_t;

    // Stage enables
    logic en1, en2, en3;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    assign en3 = !s3_valid_reg || rsp.ready;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign req.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= req.valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: capture dates and compute year / 25
    day_t   s1_d1_reg, s1_d2_reg;
    month_t s1_m1_reg, s1_m2_reg;
    year_t  s1_y1_reg, s1_y2_reg;
    logic [Q_W-1:0] s1_q1_reg, s1_q2_reg;

    gdnd_div25 #(.YEAR_BITS(YEAR_BITS)) u_div25_first (
        .clk   (clk),
        .en    (en1),
        .y     (req.first_year),
        .q_reg (s1_q1_reg)
    );

    gdnd_div25 #(.YEAR_BITS(YEAR_BITS)) u_div25_second (
        .clk   (clk),
        .en    (en1),
        .y     (req.second_year),
        .q_reg (s1_q2_reg)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_d1_reg <= req.first_day;
            s1_m1_reg <= req.first_month;
            s1_y1_reg <= req.first_year;
            s1_d2_reg <= req.second_day;
            s1_m2_reg <= req.second_month;
            s1_y2_reg <= req.second_year;
        end
    end

    // Stage 2: leap flags, month lengths, validity
    year_t q1x25, q2x25;
    logic  div25_1, div25_2, leap1, leap2;
    day_t  mlen1, mlen2, blen2_next;
    logic  v1_next, v2_next;

    assign q1x25 = {s1_q1_reg, 4'b0} + YEAR_BITS'({s1_q1_reg, 3'b0}) + YEAR_BITS'(s1_q1_reg);
    assign q2x25 = {s1_q2_reg, 4'b0} + YEAR_BITS'({s1_q2_reg, 3'b0}) + YEAR_BITS'(s1_q2_reg);
    assign div25_1 = (q1x25 == s1_y1_reg);
    assign div25_2 = (q2x25 == s1_y2_reg);
    // divisible by 4 and not a century, or divisible by 400 (16 and 25)
    assign leap1 = (s1_y1_reg[1:0] == 2'b0) && (!div25_1 || s1_y1_reg[3:0] == 4'b0);
    assign leap2 = (s1_y2_reg[1:0] == 2'b0) && (!div25_2 || s1_y2_reg[3:0] == 4'b0);

    assign mlen1      = month_len(s1_m1_reg, leap1);
    assign mlen2      = month_len(s1_m2_reg, leap2);
    assign blen2_next = prev_month_len(s1_m2_reg, leap2);

    assign v1_next = (s1_y1_reg != '0) && (s1_m1_reg != '0) && (s1_m1_reg <= MON_DEC)
                     && (s1_d1_reg != '0) && (s1_d1_reg <= mlen1);
    assign v2_next = (s1_y2_reg != '0) && (s1_m2_reg != '0) && (s1_m2_reg <= MON_DEC)
                     && (s1_d2_reg != '0) && (s1_d2_reg <= mlen2);

    day_t   s2_d1_reg, s2_d2_reg, s2_mlen1_reg, s2_blen2_reg;
    month_t s2_m1_reg, s2_m2_reg;
    year_t  s2_y1_reg, s2_y2_reg;
    logic   s2_v1_reg, s2_v2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_d1_reg    <= s1_d1_reg;
            s2_m1_reg    <= s1_m1_reg;
            s2_y1_reg    <= s1_y1_reg;
            s2_d2_reg    <= s1_d2_reg;
            s2_m2_reg    <= s1_m2_reg;
            s2_y2_reg    <= s1_y2_reg;
            s2_mlen1_reg <= mlen1;
            s2_blen2_reg <= blen2_next;
            s2_v1_reg    <= v1_next;
            s2_v2_reg    <= v2_next;
        end
    end

    // Stage 3: next date
    day_t   nd;
    month_t nm;
    year_t  ny;
    logic   ovf;

    always_comb
    begin
        nd  = '0;
        nm  = '0;
        ny  = '0;
        ovf = 1'b0;
        if (s2_v1_reg)
        begin
            nm = s2_m1_reg;
            ny = s2_y1_reg;
            if (s2_d1_reg < s2_mlen1_reg)
            begin
                nd = s2_d1_reg + 5'd1;
            end
            else
            begin
                nd = 5'd1;
                if (s2_m1_reg == MON_DEC)
                begin
                    nm = MON_JAN;
                    if (&s2_y1_reg)
                    begin
                        ovf = 1'b1;
                        ny  = '0;
                    end
                    else
                    begin
                        ny = s2_y1_reg + YEAR_BITS'(1);
                    end
                end
                else
                begin
                    nm = s2_m1_reg + 4'd1;
                end
            end
        end
    end

    // Stage 3: borrow-style difference
    logic                 borrow_d, borrow_m;
    dday_t                sd;
    month_t               sm;
    logic [4:0]           sm2;
    logic [YEAR_BITS:0]   dy;
    month_t               dm;
    dday_t                dd;

    always_comb
    begin
        borrow_d = (s2_d2_reg < s2_d1_reg);
        sd       = {1'b0, s2_d2_reg} + (borrow_d ? {1'b0, s2_blen2_reg} : dday_t'(0));
        sm       = s2_m2_reg - {3'b0, borrow_d};
        borrow_m = (sm < s2_m1_reg);
        sm2      = {1'b0, sm} + (borrow_m ? {1'b0, MONTHS_PER_YEAR} : 5'd0);
        dd       = '0;
        dm       = '0;
        dy       = '0;
        if (s2_v1_reg && s2_v2_reg)
        begin
            dd = sd - {1'b0, s2_d1_reg};
            dm = sm2[3:0] - s2_m1_reg;
            dy = {1'b0, s2_y2_reg} - {1'b0, s2_y1_reg} - (YEAR_BITS+1)'(borrow_m);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            rsp.first_valid   <= s2_v1_reg;
            rsp.second_valid  <= s2_v2_reg;
            rsp.next_day      <= nd;
            rsp.next_month    <= nm;
            rsp.next_year     <= ny;
            rsp.next_overflow <= ovf;
            rsp.diff_years    <= dy;
            rsp.diff_months   <= dm;
            rsp.diff_days     <= dd;
        end
    end

    assign rsp.valid = s3_valid_reg;
endmodule

`default_nettype wire

// ===== test/tb_gregorian_date_next_and_difference_unit.sv =====
`timescale 1ns / 1ps

module tb_gregorian_date_next_and_difference_unit;
    import gdnd_pkg::*;

    localparam int YEAR_BITS    = 14;
    localparam int YEAR_MAX     = (1 << YEAR_BITS) - 1;
    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 500000;

    // One request item: two calendar dates
    typedef struct {
        day_t                 first_day;
        month_t               first_month;
        logic [YEAR_BITS-1:0] first_year;
        day_t                 second_day;
        month_t               second_month;
        logic [YEAR_BITS-1:0] second_year;
    } date_pair_t;

    // One result item: validity, next date and borrow-style difference
    typedef struct {
        logic                      first_valid;
        logic                      second_valid;
        day_t                      next_day;
        month_t                    next_month;
        logic [YEAR_BITS-1:0]      next_year;
        logic                      next_overflow;
        logic signed [YEAR_BITS:0] diff_years;
        month_t                    diff_months;
        logic signed [DDAY_W-1:0]  diff_days;
    } date_result_t;

    // Calendar predictor plus the queue of results still owed by the block
    class date_scoreboard;
        date_result_t expected_results[$];
        int           error_count = 0;

        static function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned days_in_month(int unsigned m, int unsigned y);
            if (m == MON_FEB)
                return leap_year(y) ? 29 : 28;
            if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
                return 30;
            return 31;
        endfunction

        static function bit calendar_ok(int unsigned d, int unsigned m, int unsigned y);
            if (y < 1 || m < MON_JAN || m > MON_DEC || d < 1)
                return 1'b0;
            return d <= days_in_month(m, y);
        endfunction

        function date_result_t next_and_difference(date_pair_t p);
            date_result_t r;
            int unsigned  d1, m1, y1, d2, m2, y2, prev_m;
            int           sd, sm, sy;
            d1 = p.first_day;
            m1 = p.first_month;
            y1 = p.first_year;
            d2 = p.second_day;
            m2 = p.second_month;
            y2 = p.second_year;
            r = '{default: 0};
            r.first_valid  = calendar_ok(d1, m1, y1);
            r.second_valid = calendar_ok(d2, m2, y2);

            // one-day step of the first date
            if (r.first_valid) begin
                r.next_day   = d1;
                r.next_month = m1;
                r.next_year  = y1;
                if (d1 < days_in_month(m1, y1)) begin
                    r.next_day = d1 + 1;
                end
                else begin
                    r.next_day = 1;
                    if (m1 == MON_DEC) begin
                        r.next_month = MON_JAN;
                        if (y1 >= YEAR_MAX) begin
                            r.next_overflow = 1'b1;
                            r.next_year     = '0;
                        end
                        else begin
                            r.next_year = y1 + 1;
                        end
                    end
                    else begin
                        r.next_month = m1 + 1;
                    end
                end
            end

            // borrow the length of the month before the second month, then 12 months
            if (r.first_valid && r.second_valid) begin
                sd = d2;
                sm = m2;
                sy = y2;
                if (d2 < d1) begin
                    prev_m = (m2 == MON_JAN) ? MONTHS_PER_YEAR : m2 - 1;
                    sd += days_in_month(prev_m, y2);
                    sm -= 1;
                end
                if (sm < int'(m1)) begin
                    sm += MONTHS_PER_YEAR;
                    sy -= 1;
                end
                r.diff_days   = sd - int'(d1);
                r.diff_months = sm - int'(m1);
                r.diff_years  = sy - int'(y1);
            end
            return r;
        endfunction

        function void note_request(date_pair_t p);
            expected_results.push_back(next_and_difference(p));
        endfunction

        function void compare_field(string field, logic signed [31:0] expected,
                                    logic signed [31:0] actual);
            if (actual !== expected) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, expected, actual);
                error_count++;
            end
        endfunction

        function void check_result(date_result_t act);
            date_result_t exp;
            if (expected_results.size() == 0) begin
                $display("%0t: result item with nothing expected: next %0d/%0d/%0d",
                         $time, act.next_day, act.next_month, act.next_year);
                error_count++;
                return;
            end
            exp = expected_results.pop_front();
            compare_field("first_valid",   exp.first_valid,   act.first_valid);
            compare_field("second_valid",  exp.second_valid,  act.second_valid);
            compare_field("next_day",      exp.next_day,      act.next_day);
            compare_field("next_month",    exp.next_month,    act.next_month);
            compare_field("next_year",     exp.next_year,     act.next_year);
            compare_field("next_overflow", exp.next_overflow, act.next_overflow);
            compare_field("diff_years",    exp.diff_years,    act.diff_years);
            compare_field("diff_months",   exp.diff_months,   act.diff_months);
            compare_field("diff_days",     exp.diff_days,     act.diff_days);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    bit   calm_source = 1'b0;

    date_scoreboard sb = new();

    gdnd_req_if #(.YEAR_BITS(YEAR_BITS)) req_ch ();
    gdnd_rsp_if #(.YEAR_BITS(YEAR_BITS)) rsp_ch ();

    gregorian_date_next_and_difference_unit #(
        .YEAR_BITS(YEAR_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Gap or stall length: mostly none or short, a few long
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_year();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 9))
                0:       return 1;
                1:       return 1600;
                2:       return 1900;
                3:       return 2000;
                4:       return 2100;
                5:       return 2400;
                6:       return YEAR_MAX - 1;
                7:       return 16000;
                8:       return 4 * $urandom_range(1, YEAR_MAX / 4);
                default: return YEAR_MAX;
            endcase
        end
        if (r < 50)
            return $urandom_range(1, 3000);
        return $urandom_range(1, YEAR_MAX);
    endfunction

    // Day biased toward month ends and the first of the month
    function automatic int unsigned pick_day(int unsigned m, int unsigned y);
        int unsigned len;
        int          r;
        len = date_scoreboard::days_in_month(m, y);
        r   = $urandom_range(0, 99);
        if (r < 25)
            return len;
        if (r < 35)
            return 1;
        return $urandom_range(1, len);
    endfunction

    // Spoil one field of a date: day zero, day past month end, bad month or year zero
    function automatic void spoil_date(inout day_t d, inout month_t m,
                                       inout logic [YEAR_BITS-1:0] y);
        int unsigned len;
        len = date_scoreboard::days_in_month(m, y);
        case ($urandom_range(0, 3))
            0: d = '0;
            1: d = (len < 31) ? $urandom_range(len + 1, 31) : 0;
            2: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
            default: y = '0;
        endcase
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t p;
        int         kind;
        int         y2;
        kind = $urandom_range(0, 99);
        p.first_month = $urandom_range(MON_JAN, MON_DEC);
        p.first_year  = pick_year();
        p.first_day   = pick_day(p.first_month, p.first_year);
        p.second_month = ($urandom_range(0, 2) == 0) ? p.first_month
                                                     : $urandom_range(MON_JAN, MON_DEC);
        if ($urandom_range(0, 1)) begin
            y2 = int'(p.first_year) + $urandom_range(0, 4) - 2;
            if (y2 < 1)
                y2 = 1;
            if (y2 > YEAR_MAX)
                y2 = YEAR_MAX;
            p.second_year = y2;
        end
        else begin
            p.second_year = pick_year();
        end
        p.second_day = pick_day(p.second_month, p.second_year);

        if (kind >= 90) begin
            // raw noise over every field
            p.first_day    = $urandom;
            p.first_month  = $urandom;
            p.first_year   = $urandom;
            p.second_day   = $urandom;
            p.second_month = $urandom;
            p.second_year  = $urandom;
        end
        else if (kind >= 80) begin
            if ($urandom_range(0, 1))
                spoil_date(p.first_day, p.first_month, p.first_year);
            else
                spoil_date(p.second_day, p.second_month, p.second_year);
        end
        return p;
    endfunction

    function automatic date_pair_t make_pair(int d1, int m1, int y1, int d2, int m2, int y2);
        date_pair_t p;
        p.first_day    = d1;
        p.first_month  = m1;
        p.first_year   = y1;
        p.second_day   = d2;
        p.second_month = m2;
        p.second_year  = y2;
        return p;
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_pair(date_pair_t p);
        int gap;
        gap = pick_gap(calm_source);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.first_day    <= p.first_day;
        req_ch.first_month  <= p.first_month;
        req_ch.first_year   <= p.first_year;
        req_ch.second_day   <= p.second_day;
        req_ch.second_month <= p.second_month;
        req_ch.second_year  <= p.second_year;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Note accepted request items
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_request(make_pair(req_ch.first_day, req_ch.first_month,
                                      req_ch.first_year, req_ch.second_day,
                                      req_ch.second_month, req_ch.second_year));
    end

    // Check accepted result items
    always @(posedge clk)
    begin
        date_result_t act;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            act.first_valid   = rsp_ch.first_valid;
            act.second_valid  = rsp_ch.second_valid;
            act.next_day      = rsp_ch.next_day;
            act.next_month    = rsp_ch.next_month;
            act.next_year     = rsp_ch.next_year;
            act.next_overflow = rsp_ch.next_overflow;
            act.diff_years    = rsp_ch.diff_years;
            act.diff_months   = rsp_ch.diff_months;
            act.diff_days     = rsp_ch.diff_days;
            sb.check_result(act);
        end
    end

    // Result side: ready runs broken by stalls, with calm stretches
    initial
    begin
        int run;
        int stall;
        int bursts;
        bit calm_sink;
        bursts    = 0;
        calm_sink = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (bursts % 40 == 0)
                calm_sink = ($urandom_range(0, 3) == 0);
            bursts++;
            run = $urandom_range(1, 16);
            rsp_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap(calm_sink);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Reset, directed items, random items, drain
    initial
    begin
        int n;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.first_day    <= '0;
        req_ch.first_month  <= '0;
        req_ch.first_year   <= '0;
        req_ch.second_day   <= '0;
        req_ch.second_month <= '0;
        req_ch.second_year  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // year overflow on the last day of the last year
        send_pair(make_pair(31, MON_DEC, YEAR_MAX, 1, MON_JAN, 1));
        send_pair(make_pair(31, MON_DEC, YEAR_MAX - 1, 1, MON_JAN, YEAR_MAX));
        send_pair(make_pair(1, MON_JAN, 1, 31, MON_DEC, YEAR_MAX));
        // leap rules: by 4, not by 100, by 400
        send_pair(make_pair(28, MON_FEB, 2000, 29, MON_FEB, 2000));
        send_pair(make_pair(29, MON_FEB, 2000, 1, MON_MAR, 2000));
        send_pair(make_pair(28, MON_FEB, 1900, 1, MON_MAR, 1900));
        send_pair(make_pair(29, MON_FEB, 1900, 1, MON_MAR, 1900));
        send_pair(make_pair(29, MON_FEB, 2004, 29, MON_FEB, 2008));
        send_pair(make_pair(28, MON_FEB, YEAR_MAX, 28, MON_FEB, YEAR_MAX));
        // day borrows from the month before, negative after a February borrow
        send_pair(make_pair(31, MON_JAN, 2023, 1, MON_MAR, 2023));
        send_pair(make_pair(31, MON_JAN, 2024, 1, MON_MAR, 2024));
        send_pair(make_pair(31, 8, 1600, 1, MON_MAR, 1600));
        send_pair(make_pair(31, MON_MAR, 2001, 30, MON_MAY, 2001));
        // borrow on both day and month, year rollover, zero difference
        send_pair(make_pair(15, MON_JUN, 2000, 10, MON_MAR, 2010));
        send_pair(make_pair(31, MON_DEC, 2023, 1, MON_JAN, 2024));
        send_pair(make_pair(30, MON_APR, 100, 30, MON_APR, 100));
        // invalid dates: day zero, day past month end, bad month, year zero
        send_pair(make_pair(0, MON_MAY, 10, 5, MON_MAY, 10));
        send_pair(make_pair(31, MON_APR, 10, 1, MON_MAY, 10));
        send_pair(make_pair(1, 0, 10, 1, MON_JAN, 10));
        send_pair(make_pair(1, 13, 10, 1, MON_JAN, 10));
        send_pair(make_pair(1, MON_JAN, 0, 1, MON_JAN, 1));
        send_pair(make_pair(1, MON_JAN, 5, 0, 0, 0));
        send_pair(make_pair(31, 15, YEAR_MAX, 31, 15, YEAR_MAX));
        send_pair(make_pair(0, 0, 0, 0, 0, 0));

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                calm_source = ($urandom_range(0, 3) == 0);
            send_pair(random_pair());
        end
        req_ch.valid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge clk);

        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gdnd_pkg.sv
rtl/core/gdnd_if.sv
rtl/core/gdnd_div25.sv
rtl/core/gregorian_date_next_and_difference_unit.sv
test/tb_gregorian_date_next_and_difference_unit.sv
